[hdl/qpmc_pkg.sv]
`default_nettype none

package qpmc_pkg;

   // Event codes carried by the func field of an input word.
   localparam logic [2:0] FUNC_SAMPLE  = 3'd0;
   localparam logic [2:0] FUNC_EXTEND  = 3'd1;
   localparam logic [2:0] FUNC_RETRACT = 3'd2;
   localparam logic [2:0] FUNC_STOP    = 3'd3;
   localparam logic [2:0] FUNC_PRESS   = 3'd4;

   // Configuration register indexes (byte address bits [3:2]).
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_SLOW_DUTY      = 2'd0;
   localparam logic [1:0] REG_SLOW_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_RETRACT_LIMIT  = 2'd2;

   // Register reset values. The threshold is 270 / 0.6545 rounded up, the
   // limit is -210 / 0.6545 + 15 rounded down, i.e. -306.
   localparam logic [7:0]  SLOW_DUTY_RST      = 8'd32;
   localparam logic [14:0] SLOW_THRESHOLD_RST = 15'd413;
   localparam logic [15:0] RETRACT_LIMIT_RST  = 16'hFECE;

   // Saturation bounds of the position count.
   localparam logic [15:0] CNT_MAX = 16'h7FFF;
   localparam logic [15:0] CNT_MIN = 16'h8000;

   // Direction of one quadrature transition.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // One input word.
   typedef struct packed {
      logic [2:0] func;
      logic       enc_a;
      logic       enc_b;
      logic       switch_open;
      logic [7:0] duty;
      logic       clear_count;
   } cmd_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [7:0]  slow_duty;
      logic [14:0] slow_threshold;
      logic [15:0] retract_limit;
   } cfg_type;

   // Controller state; the result word is read straight from it.
   typedef struct packed {
      logic [15:0] pos_count;
      logic [1:0]  last_phase;
      logic        extend_flag;
      logic        stop_flag;
      logic        swept_flag;
      logic        slow_flag;
      logic [7:0]  fwd_level;
      logic [7:0]  back_level;
   } state_type;

   localparam state_type STATE_RST = '{
      pos_count:   16'd0,
      last_phase:  2'd0,
      extend_flag: 1'b0,
      stop_flag:   1'b1,
      swept_flag:  1'b0,
      slow_flag:   1'b0,
      fwd_level:   8'd0,
      back_level:  8'd0
   };

   // Quadrature transition table indexed by {new phase, old phase}.
   function automatic dir_type phase_dir(input logic [3:0] full);
      dir_type d;
      unique case (full)
         4'b0001, 4'b1000, 4'b0111, 4'b1110: d = DIR_UP;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_DOWN;
         default:                            d = DIR_NONE;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[hdl/qpmc_csr.sv]
`default_nettype none

module qpmc_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [qpmc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready,
   output qpmc_pkg::cfg_type                          cfg
);

   qpmc_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // Register writes; addresses past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_duty      <= qpmc_pkg::SLOW_DUTY_RST;
         cfg_ff.slow_threshold <= qpmc_pkg::SLOW_THRESHOLD_RST;
         cfg_ff.retract_limit  <= qpmc_pkg::RETRACT_LIMIT_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            qpmc_pkg::REG_SLOW_DUTY:      cfg_ff.slow_duty      <= pwdata[7:0];
            qpmc_pkg::REG_SLOW_THRESHOLD: cfg_ff.slow_threshold <= pwdata[14:0];
            qpmc_pkg::REG_RETRACT_LIMIT:  cfg_ff.retract_limit  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux; the retract limit is returned sign-extended.
   always_comb begin
      unique case (reg_idx)
         qpmc_pkg::REG_SLOW_DUTY:      prdata = {24'd0, cfg_ff.slow_duty};
         qpmc_pkg::REG_SLOW_THRESHOLD: prdata = {17'd0, cfg_ff.slow_threshold};
         qpmc_pkg::REG_RETRACT_LIMIT:
            prdata = {{16{cfg_ff.retract_limit[15]}}, cfg_ff.retract_limit};
         default:                      prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

[hdl/qpmc_step.sv]
`default_nettype none

module qpmc_step (
   input  wire qpmc_pkg::cmd_type   cmd,
   input  wire qpmc_pkg::cfg_type   cfg,
   input  wire qpmc_pkg::state_type cur,
   output qpmc_pkg::state_type      nxt
);

   logic [1:0]        now_phase;
   qpmc_pkg::dir_type dir;
   logic [15:0]       cnt_step;
   logic [15:0]       thr_ext;

   assign now_phase = {cmd.enc_a, cmd.enc_b};
   assign dir       = qpmc_pkg::phase_dir({now_phase, cur.last_phase});
   assign thr_ext   = {1'b0, cfg.slow_threshold};

   // Saturating up/down count for an encoder sample.
   always_comb begin
      unique case (dir)
         qpmc_pkg::DIR_UP:
            cnt_step = (cur.pos_count != qpmc_pkg::CNT_MAX) ?
                       cur.pos_count + 16'd1 : cur.pos_count;
         qpmc_pkg::DIR_DOWN:
            cnt_step = (cur.pos_count != qpmc_pkg::CNT_MIN) ?
                       cur.pos_count - 16'd1 : cur.pos_count;
         default:
            cnt_step = cur.pos_count;
      endcase
   end

   // Next controller state for one event.
   always_comb begin
      nxt = cur;
      unique case (cmd.func)
         qpmc_pkg::FUNC_SAMPLE: begin
            nxt.pos_count  = cnt_step;
            nxt.last_phase = now_phase;
            if (!cur.extend_flag && !cur.stop_flag) begin
               // Retracting: stop once the limit is reached.
               if ($signed(cnt_step) <= $signed(cfg.retract_limit)) begin
                  nxt.fwd_level   = 8'd0;
                  nxt.back_level  = 8'd0;
                  nxt.extend_flag = 1'b0;
                  nxt.stop_flag   = 1'b1;
                  nxt.swept_flag  = 1'b1;
               end
            end else if (cur.extend_flag && !cur.slow_flag &&
                         $signed(cnt_step) >= $signed(thr_ext)) begin
               // Extending to the threshold: restart at slow duty if the switch is open.
               if (cmd.switch_open) begin
                  nxt.pos_count   = 16'd0;
                  nxt.extend_flag = 1'b1;
                  nxt.stop_flag   = 1'b0;
                  nxt.fwd_level   = cfg.slow_duty;
                  nxt.back_level  = 8'd0;
               end
               nxt.slow_flag = 1'b1;
            end
         end
         qpmc_pkg::FUNC_EXTEND: begin
            if (cmd.switch_open) begin
               nxt.pos_count   = 16'd0;
               nxt.extend_flag = 1'b1;
               nxt.stop_flag   = 1'b0;
               nxt.slow_flag   = 1'b0;
               nxt.fwd_level   = cmd.duty;
               nxt.back_level  = 8'd0;
            end
         end
         qpmc_pkg::FUNC_RETRACT: begin
            nxt.swept_flag = 1'b0;
            if (cmd.clear_count) begin
               nxt.pos_count = 16'd0;
            end
            nxt.stop_flag  = 1'b0;
            nxt.fwd_level  = 8'd0;
            nxt.back_level = cmd.duty;
         end
         qpmc_pkg::FUNC_STOP: begin
            nxt.fwd_level   = 8'd0;
            nxt.back_level  = 8'd0;
            nxt.extend_flag = 1'b0;
            nxt.stop_flag   = 1'b1;
         end
         qpmc_pkg::FUNC_PRESS: begin
            if (cur.extend_flag) begin
               nxt.fwd_level   = 8'd0;
               nxt.back_level  = 8'd0;
               nxt.extend_flag = 1'b0;
               nxt.stop_flag   = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[hdl/quadrature_positioned_motor_control_unit.sv]
`default_nettype none

// Motor controller with quadrature position decoding. Each accepted request
// word is one event (encoder sample, extend, retract, stop or limit-switch
// press) and yields exactly one response word with the drive levels, the
// status flags and the saturating signed position count after that event.
// The block takes one word per clock cycle while req_stall is low: the word is
// captured in an input register, the state update is a single pass of logic
// (one 16-bit increment/decrement followed by one compare against a threshold),
// and the response is held in an output register, so a response is offered
// once its word has passed the input and then the output register. While a
// response waits under rsp_stall one more request is still taken. Configuration
// is written through the APB port and must only change while no word is in flight.
module quadrature_positioned_motor_control_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [2:0]                      req_func,
   input  wire logic                            req_enc_a,
   input  wire logic                            req_enc_b,
   input  wire logic                            req_switch_open,
   input  wire logic [7:0]                      req_duty,
   input  wire logic                            req_clear_count,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_forward_drive,
   output logic [7:0]                           rsp_backward_drive,
   output logic                                 rsp_is_extending,
   output logic                                 rsp_is_stopped,
   output logic                                 rsp_is_swept,
   output logic signed [15:0]                   rsp_position,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [qpmc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   qpmc_pkg::cfg_type   cfg;
   qpmc_pkg::cmd_type   cmd_ff;
   qpmc_pkg::state_type state_ff;
   qpmc_pkg::state_type state_in;
   qpmc_pkg::state_type rsp_ff;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                req_take;
   logic                advance;

   qpmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qpmc_step u_step (
      .cmd (cmd_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in)
   );

   // A word moves from the input register to the output register whenever
   // the output register is empty or is being taken this cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Pipeline control and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= qpmc_pkg::STATE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff.func        <= req_func;
         cmd_ff.enc_a       <= req_enc_a;
         cmd_ff.enc_b       <= req_enc_b;
         cmd_ff.switch_open <= req_switch_open;
         cmd_ff.duty        <= req_duty;
         cmd_ff.clear_count <= req_clear_count;
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= state_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forward_drive  = rsp_ff.fwd_level;
   assign rsp_backward_drive = rsp_ff.back_level;
   assign rsp_is_extending   = rsp_ff.extend_flag;
   assign rsp_is_stopped     = rsp_ff.stop_flag;
   assign rsp_is_swept       = rsp_ff.swept_flag;
   assign rsp_position       = $signed(rsp_ff.pos_count);

endmodule

`default_nettype wire

[hdl/qpmc_checker.sv]
`default_nettype none

module qpmc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [7:0]         rsp_forward_drive,
   input wire logic [7:0]         rsp_backward_drive,
   input wire logic               rsp_is_extending,
   input wire logic               rsp_is_stopped,
   input wire logic signed [15:0] rsp_position
);

   // No response word is shown in the cycle after reset.
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response word stays and keeps its position.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position))
      else $error("stalled response word changed");

   // A stopped motor has no drive in either direction.
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_stopped |->
         rsp_forward_drive == 8'd0 && rsp_backward_drive == 8'd0)
      else $error("drive active while stopped");

   // Extending and stopped never hold together.
   a_ext_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_extending && rsp_is_stopped))
      else $error("extending while stopped");

   // Forward drive only comes from an extension in progress.
   a_fwd_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward_drive != 8'd0 |-> rsp_is_extending)
      else $error("forward drive without extension");

endmodule

bind quadrature_positioned_motor_control_unit qpmc_checker u_qpmc_checker (.*);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SHOW_LIMIT  = 10;
   localparam int LONG_HOLD   = 300;

   // Function codes that the block treats as no operation.
   localparam logic [2:0] FUNC_LAST_CODE = 3'd7;

   // Saturation bounds of the signed position count.
   localparam logic signed [15:0] POS_CEIL  = 16'sh7FFF;
   localparam logic signed [15:0] POS_FLOOR = 16'sh8000;

   // One response word as seen on the rsp_ ports.
   typedef struct packed {
      logic [7:0]  fwd_drive;
      logic [7:0]  back_drive;
      logic        extending;
      logic        stopped;
      logic        swept;
      logic [15:0] position;
   } motor_status_type;

   // Tracks the motor state, predicts each response and checks the block.
   class motor_scoreboard;
      logic [7:0]         slow_duty;
      logic [14:0]        slow_thr;
      logic signed [15:0] retract_lim;
      logic signed [15:0] pos;
      logic [1:0]         last_ph;
      bit                 ext_f;
      bit                 stop_f;
      bit                 swept_f;
      bit                 slow_f;
      logic [7:0]         fwd;
      logic [7:0]         back;
      motor_status_type   status_due[$];
      int                 words_noted;
      int                 results_checked;
      int                 errors;

      function new();
         slow_duty   = qpmc_pkg::SLOW_DUTY_RST;
         slow_thr    = qpmc_pkg::SLOW_THRESHOLD_RST;
         retract_lim = qpmc_pkg::RETRACT_LIMIT_RST;
         pos         = '0;
         last_ph     = '0;
         ext_f       = 1'b0;
         stop_f      = 1'b1;
         swept_f     = 1'b0;
         slow_f      = 1'b0;
         fwd         = '0;
         back        = '0;
      endfunction

      function void flag_error(string msg);
         errors++;
         if (errors <= SHOW_LIMIT)
            $display("ERROR: %s", msg);
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            qpmc_pkg::REG_SLOW_DUTY:      slow_duty   = value[7:0];
            qpmc_pkg::REG_SLOW_THRESHOLD: slow_thr    = value[14:0];
            qpmc_pkg::REG_RETRACT_LIMIT:  retract_lim = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            qpmc_pkg::REG_SLOW_DUTY:      return {24'd0, slow_duty};
            qpmc_pkg::REG_SLOW_THRESHOLD: return {17'd0, slow_thr};
            qpmc_pkg::REG_RETRACT_LIMIT:  return {16'd0, retract_lim};
            default:                      return '0;
         endcase
      endfunction

      // Gray order 00, 01, 11, 10: a step back in that order counts up.
      function int quad_move(logic [1:0] from, logic [1:0] to);
         logic [1:0] i_from;
         logic [1:0] i_to;
         logic [1:0] d;
         i_from = {from[1], from[1] ^ from[0]};
         i_to   = {to[1], to[1] ^ to[0]};
         d      = i_to - i_from;
         if (d == 2'd3)
            return 1;
         if (d == 2'd1)
            return -1;
         return 0;
      endfunction

      function void halt();
         fwd    = '0;
         back   = '0;
         ext_f  = 1'b0;
         stop_f = 1'b1;
      endfunction

      function void start_extend(logic [7:0] level, logic sw_open);
         if (sw_open) begin
            pos    = '0;
            ext_f  = 1'b1;
            stop_f = 1'b0;
            slow_f = 1'b0;
            fwd    = level;
            back   = '0;
         end
      endfunction

      function void take_sample(logic [1:0] now, logic sw_open);
         int mv;
         mv = quad_move(last_ph, now);
         if (mv > 0 && pos != POS_CEIL)
            pos = pos + 16'sd1;
         else if (mv < 0 && pos != POS_FLOOR)
            pos = pos - 16'sd1;
         last_ph = now;
         // Retraction ends at the limit; extension slows down at the threshold.
         if (!ext_f && !stop_f) begin
            if (pos <= retract_lim) begin
               halt();
               swept_f = 1'b1;
            end
         end else if (ext_f && !slow_f && pos >= $signed({1'b0, slow_thr})) begin
            start_extend(slow_duty, sw_open);
            slow_f = 1'b1;
         end
      endfunction

      // Called for every request word the block accepts.
      function void note_word(qpmc_pkg::cmd_type c);
         motor_status_type want;
         case (c.func)
            qpmc_pkg::FUNC_SAMPLE:  take_sample({c.enc_a, c.enc_b}, c.switch_open);
            qpmc_pkg::FUNC_EXTEND:  start_extend(c.duty, c.switch_open);
            qpmc_pkg::FUNC_RETRACT: begin
               swept_f = 1'b0;
               if (c.clear_count)
                  pos = '0;
               stop_f = 1'b0;
               fwd    = '0;
               back   = c.duty;
            end
            qpmc_pkg::FUNC_STOP:    halt();
            qpmc_pkg::FUNC_PRESS:   if (ext_f) halt();
            default: ;
         endcase
         want.fwd_drive  = fwd;
         want.back_drive = back;
         want.extending  = ext_f;
         want.stopped    = stop_f;
         want.swept      = swept_f;
         want.position   = pos;
         status_due.push_back(want);
         words_noted++;
      endfunction

      // Called for every response word the testbench takes.
      function void check_status(motor_status_type got);
         motor_status_type want;
         results_checked++;
         if (status_due.size() == 0) begin
            flag_error("response word arrived with none outstanding");
            return;
         end
         want = status_due.pop_front();
         if (got.fwd_drive !== want.fwd_drive || got.back_drive !== want.back_drive ||
             got.extending !== want.extending || got.stopped !== want.stopped ||
             got.swept !== want.swept || got.position !== want.position)
            flag_error($sformatf({"response %0d: fwd %0d/%0d back %0d/%0d ext %b/%b ",
                                  "stop %b/%b swept %b/%b pos %0d/%0d (exp/got)"},
               results_checked, want.fwd_drive, got.fwd_drive, want.back_drive,
               got.back_drive, want.extending, got.extending, want.stopped, got.stopped,
               want.swept, got.swept, $signed(want.position), $signed(got.position)));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid;
   logic                            req_stall;
   logic [2:0]                      req_func;
   logic                            req_enc_a;
   logic                            req_enc_b;
   logic                            req_switch_open;
   logic [7:0]                      req_duty;
   logic                            req_clear_count;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [7:0]                      rsp_forward_drive;
   logic [7:0]                      rsp_backward_drive;
   logic                            rsp_is_extending;
   logic                            rsp_is_stopped;
   logic                            rsp_is_swept;
   logic signed [15:0]              rsp_position;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [qpmc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                     pwdata;
   logic [31:0]                     prdata;
   logic                            pready;

   motor_scoreboard  sb = new();
   motor_status_type rsp_word;
   int               gap_pct;
   int               stall_pct;
   int               hold_left;
   int               holds_done;
   int               settings_used;
   int               words_sent;
   int               cycle_count;
   logic [1:0]       walk [16] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                   2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

   quadrature_positioned_motor_control_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_enc_a          (req_enc_a),
      .req_enc_b          (req_enc_b),
      .req_switch_open    (req_switch_open),
      .req_duty           (req_duty),
      .req_clear_count    (req_clear_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_forward_drive  (rsp_forward_drive),
      .rsp_backward_drive (rsp_backward_drive),
      .rsp_is_extending   (rsp_is_extending),
      .rsp_is_stopped     (rsp_is_stopped),
      .rsp_is_swept       (rsp_is_swept),
      .rsp_position       (rsp_position),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // Clock with a period of 8.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("quadrature_positioned_motor_control_unit test failed");
         $finish;
      end
   end

   // Response side: check each taken word, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_word.fwd_drive  = rsp_forward_drive;
         rsp_word.back_drive = rsp_backward_drive;
         rsp_word.extending  = rsp_is_extending;
         rsp_word.stopped    = rsp_is_stopped;
         rsp_word.swept      = rsp_is_swept;
         rsp_word.position   = rsp_position;
         sb.check_status(rsp_word);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic qpmc_pkg::cmd_type mk_word(logic [2:0] f, logic a, logic b,
                                                 logic sw, logic [7:0] d, logic clr);
      qpmc_pkg::cmd_type c;
      c.func        = f;
      c.enc_a       = a;
      c.enc_b       = b;
      c.switch_open = sw;
      c.duty        = d;
      c.clear_count = clr;
      return c;
   endfunction

   function automatic qpmc_pkg::cmd_type rand_word();
      return mk_word(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
   endfunction

   // Command word with the given code and random don't-care fields.
   function automatic qpmc_pkg::cmd_type cmd_word(logic [2:0] f);
      return mk_word(f, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
   endfunction

   // Next encoder phase for one step of rotation in the given direction.
   function automatic logic [1:0] next_phase(logic [1:0] p, bit up);
      logic [1:0] i;
      i = {p[1], p[1] ^ p[0]};
      i = up ? i - 2'd1 : i + 2'd1;
      return {i[1], i[1] ^ i[0]};
   endfunction

   // Offer one request word, idling first at random, and wait until taken.
   task automatic send_word(input qpmc_pkg::cmd_type c);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= c.func;
      req_enc_a       <= c.enc_a;
      req_enc_b       <= c.enc_b;
      req_switch_open <= c.switch_open;
      req_duty        <= c.duty;
      req_clear_count <= c.clear_count;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_word(c);
      words_sent++;
   endtask

   task automatic move_sample(input bit up);
      logic [1:0] ph;
      ph = next_phase(sb.last_ph, up);
      send_word(mk_word(qpmc_pkg::FUNC_SAMPLE, ph[1], ph[0], 1'($urandom_range(3) != 0),
                        8'($urandom_range(255)), 1'($urandom_range(1))));
   endtask

   // Stop offering and wait until every response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.status_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup phase, access phase, then back to idle.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // APB read of one register, compared within the register's width.
   task automatic csr_check(input logic [1:0] idx);
      logic [31:0] got;
      logic [31:0] mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      got     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (idx)
         qpmc_pkg::REG_SLOW_DUTY:      mask = 32'h0000_00FF;
         qpmc_pkg::REG_SLOW_THRESHOLD: mask = 32'h0000_7FFF;
         default:                      mask = 32'h0000_FFFF;
      endcase
      if ((got & mask) !== sb.reg_value(idx))
         sb.flag_error($sformatf("register %0d read %h, expected %h", idx, got & mask,
                                 sb.reg_value(idx)));
   endtask

   task automatic apply_config(input int duty, input int thr, input int lim);
      int r;
      csr_write(qpmc_pkg::REG_SLOW_DUTY, 32'(duty) & 32'h0000_00FF);
      csr_write(qpmc_pkg::REG_SLOW_THRESHOLD, 32'(thr) & 32'h0000_7FFF);
      csr_write(qpmc_pkg::REG_RETRACT_LIMIT, 32'(lim) & 32'h0000_FFFF);
      for (r = 0; r <= int'(qpmc_pkg::REG_RETRACT_LIMIT); r++)
         csr_check(2'(r));
      settings_used++;
   endtask

   // Mostly extend and retract strokes with steady rotation, plus noise words.
   task automatic random_traffic(input int n_words);
      int  start;
      int  kind;
      int  len;
      int  k;
      bit  up;
      start = words_sent;
      while (words_sent - start < n_words) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            repeat ($urandom_range(6, 1)) send_word(rand_word());
         end else begin
            up = (kind < 60);
            if (up)
               send_word(mk_word(qpmc_pkg::FUNC_EXTEND, 1'($urandom_range(1)),
                                 1'($urandom_range(1)), 1'($urandom_range(9) != 0),
                                 8'($urandom_range(255)), 1'($urandom_range(1))));
            else
               send_word(mk_word(qpmc_pkg::FUNC_RETRACT, 1'($urandom_range(1)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)), 1'($urandom_range(3) == 0)));
            len = $urandom_range(70, 3);
            for (k = 0; k < len; k++) begin
               if ($urandom_range(12) == 0)
                  send_word(rand_word());
               else
                  move_sample(up ^ ($urandom_range(19) == 0));
            end
            // Strokes end with a switch press, a stop, or simply run on.
            case ($urandom_range(4))
               0: send_word(cmd_word(qpmc_pkg::FUNC_PRESS));
               1: send_word(cmd_word(qpmc_pkg::FUNC_STOP));
               default: ;
            endcase
         end
      end
   endtask

   initial begin
      int f;
      int i;
      int ph;
      req_valid       <= 1'b0;
      req_func        <= qpmc_pkg::FUNC_SAMPLE;
      req_enc_a       <= 1'b0;
      req_enc_b       <= 1'b0;
      req_switch_open <= 1'b0;
      req_duty        <= '0;
      req_clear_count <= 1'b0;
      rsp_stall       <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      gap_pct   = 0;
      stall_pct = 0;
      hold_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers come out of reset at their documented values.
      for (i = 0; i <= int'(qpmc_pkg::REG_RETRACT_LIMIT); i++)
         csr_check(2'(i));

      // Directed words under the reset settings.
      for (f = int'(qpmc_pkg::FUNC_PRESS) + 1; f <= int'(FUNC_LAST_CODE); f++)
         send_word(mk_word(3'(f), 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1));
      send_word(mk_word(qpmc_pkg::FUNC_PRESS, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
      send_word(mk_word(qpmc_pkg::FUNC_EXTEND, 1'b0, 1'b0, 1'b0, 8'd77, 1'b0));
      send_word(mk_word(qpmc_pkg::FUNC_EXTEND, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0));
      // Every ordered pair of encoder phases, starting from phase zero.
      for (i = 0; i < 16; i++)
         send_word(mk_word(qpmc_pkg::FUNC_SAMPLE, walk[i][1], walk[i][0], 1'b1, 8'h55,
                           1'b0));
      // Retract while extending keeps the extend flag, so a press then stops.
      send_word(mk_word(qpmc_pkg::FUNC_RETRACT, 1'b0, 1'b0, 1'b1, 8'hAA, 1'b1));
      send_word(mk_word(qpmc_pkg::FUNC_PRESS, 1'b1, 1'b0, 1'b0, 8'h01, 1'b0));
      send_word(mk_word(qpmc_pkg::FUNC_EXTEND, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0));
      send_word(mk_word(qpmc_pkg::FUNC_STOP, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
      drain();

      // Strokes that go negative with the threshold and limit at their far extremes.
      apply_config($urandom_range(255), 32767, -32768);
      send_word(mk_word(qpmc_pkg::FUNC_STOP, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
      repeat (24) move_sample(1'b1);
      send_word(mk_word(qpmc_pkg::FUNC_RETRACT, 1'b0, 1'b0, 1'b1, 8'd200, 1'b0));
      repeat (48) move_sample(1'b0);
      send_word(mk_word(qpmc_pkg::FUNC_EXTEND, 1'b0, 1'b0, 1'b1, 8'd150, 1'b0));
      repeat (24) move_sample(1'b1);
      send_word(mk_word(qpmc_pkg::FUNC_STOP, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
      drain();

      // Random strokes under four handshake mixes and several settings.
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
               apply_config($urandom_range(255), $urandom_range(40), -$urandom_range(40));
            end
            1: begin
               gap_pct   = 71;
               stall_pct = 0;
               apply_config(0, 0, 0);
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 71;
               apply_config($urandom_range(255), $urandom_range(40), -$urandom_range(40));
            end
            default: begin
               gap_pct   = 16;
               stall_pct = 16;
               apply_config(255, $urandom_range(40), -$urandom_range(40));
            end
         endcase
         random_traffic(150);
         // Long receiver hold while requests keep coming, so the block backs up.
         hold_left = LONG_HOLD;
         holds_done++;
         random_traffic(75);
         drain();
         random_traffic(75);
         drain();
      end

      $display("Covered %0d request words and %0d responses over %0d register settings,",
               words_sent, sb.results_checked, settings_used);
      $display("with %0d long receiver holds and %0d mismatches.",
               holds_done, sb.errors);
      if (sb.errors == 0 && sb.status_due.size() == 0)
         $display("quadrature_positioned_motor_control_unit test passed");
      else
         $display("quadrature_positioned_motor_control_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hdl/qpmc_pkg.sv
hdl/qpmc_csr.sv
hdl/qpmc_step.sv
hdl/quadrature_positioned_motor_control_unit.sv
hdl/qpmc_checker.sv
tb/tb.sv
